// ----- hdl/kmcl_pkg.sv -----
// Shared types, codes and constants of the keypad multi-area code lock.
`default_nettype none

package kmcl_pkg;

  // Default sizes of the code store
  localparam int unsigned NumAreasDef   = 3;
  localparam int unsigned CodeLengthDef = 4;

  // Configuration port
  localparam int unsigned CfgAddrW      = 3;
  localparam int unsigned CfgDataW      = 32;
  localparam logic        RegAdminCode  = 1'b0;
  localparam logic [15:0] AdminCodeRst  = 16'h1234;

  // Key codes
  localparam logic [3:0] KeyModeAdmin = 4'd1;
  localparam logic [3:0] KeyModeVisit = 4'd2;
  localparam logic [3:0] KeyFirstArea = 4'd1;
  localparam logic [3:0] KeyStar      = 4'd10;
  localparam logic [3:0] KeyNone      = 4'd12;

  // Reset contents of the stores
  localparam logic [3:0] NibEmpty = 4'hF;
  localparam logic [3:0] NibNever = 4'hE;

  typedef enum logic [2:0] {
    PG_START,
    PG_MODE,
    PG_ADMIN_ENTRY,
    PG_ADMIN_AREA,
    PG_NEW_CODE,
    PG_VISIT_AREA,
    PG_VISIT_ENTRY
  } page_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MODE_PROMPT,
    ST_ADMIN_PROMPT,
    ST_AREA_PROMPT,
    ST_WRONG_CHOICE,
    ST_KEY_TAKEN,
    ST_ADMIN_OK,
    ST_WRONG_CODE,
    ST_CODE_CHANGED,
    ST_GATE_OPEN,
    ST_CODE_PROMPT
  } status_e;

  // One result item
  typedef struct packed {
    status_e    status;
    logic       gate_open;
    logic [2:0] entry_position;
  } res_t;

  // Nibble n of the admin code, counted from the bottom; zero above bit 15
  function automatic logic [3:0] admin_nibble(input logic [15:0] code,
                                              input int unsigned n);
    logic [3:0] nib;
    case (n)
      0:       nib = code[3:0];
      1:       nib = code[7:4];
      2:       nib = code[11:8];
      3:       nib = code[15:12];
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/kmcl_cfg_regs.sv -----
// APB-style register file holding the admin code.
`default_nettype none

module kmcl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmcl_pkg::CfgAddrW-1:0] paddr,
  input  logic [kmcl_pkg::CfgDataW-1:0] pwdata,
  output logic [kmcl_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output logic [15:0]                   admin_code_o
);
  import kmcl_pkg::*;

  logic        reg_idx;
  logic        wr_en;
  logic [15:0] admin_code_q;

  // Register index is the word address
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the admin code on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      admin_code_q <= AdminCodeRst;
    end else if (wr_en && (reg_idx == RegAdminCode)) begin
      admin_code_q <= pwdata[15:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == RegAdminCode) begin
      prdata = {{(CfgDataW-16){1'b0}}, admin_code_q};
    end
  end

  assign admin_code_o = admin_code_q;

endmodule

`default_nettype wire

// ----- hdl/kmcl_menu.sv -----
// Menu state machine with entry buffer, area code store and code compare.
`default_nettype none

module kmcl_menu #(
  parameter int unsigned NUM_AREAS   = kmcl_pkg::NumAreasDef,
  parameter int unsigned CODE_LENGTH = kmcl_pkg::CodeLengthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [3:0]       key_i,
  input  logic [15:0]      admin_code_i,
  output kmcl_pkg::res_t   res_o
);
  import kmcl_pkg::*;

  localparam int unsigned CntW  = $clog2(CODE_LENGTH + 1);
  localparam int unsigned PosW  = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int unsigned AreaW = (NUM_AREAS > 1) ? $clog2(NUM_AREAS) : 1;

  page_e             page_q, page_d;
  logic [CntW-1:0]   key_count_q, key_count_d;
  logic [AreaW-1:0]  sel_q;
  logic [3:0]        entry_q [CODE_LENGTH];
  logic [3:0]        area_q  [NUM_AREAS][CODE_LENGTH];
  logic [3:0]        cand    [CODE_LENGTH];

  logic              key_none, is_star, area_ok, full;
  logic [PosW-1:0]   wr_pos;
  logic              match_admin, match_area;
  logic              clr_cnt, take, wr_entry, wr_area, set_area;
  status_e           status;
  logic              gate;

  // Decode the key
  assign key_none = (key_i >= KeyNone);
  assign is_star  = (key_i == KeyStar);
  assign area_ok  = (key_i >= KeyFirstArea) && (key_i <= 4'(NUM_AREAS));
  assign full     = (key_count_q == CntW'(CODE_LENGTH));
  assign wr_pos   = key_count_q[PosW-1:0];

  // Merge this key into the buffer image and compare all positions
  always_comb begin
    match_admin = 1'b1;
    match_area  = 1'b1;
    for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
      cand[i] = (!full && (wr_pos == PosW'(i))) ? key_i : entry_q[i];
      if (cand[i] != admin_nibble(admin_code_i, CODE_LENGTH - 1 - i)) begin
        match_admin = 1'b0;
      end
      if (cand[i] != area_q[sel_q][i]) begin
        match_area = 1'b0;
      end
    end
  end

  // Next page
  always_comb begin
    page_d = page_q;
    case (page_q)
      PG_MODE: begin
        if (!key_none) begin
          if (key_i == KeyModeAdmin) begin
            page_d = PG_ADMIN_ENTRY;
          end else if (key_i == KeyModeVisit) begin
            page_d = PG_VISIT_AREA;
          end else begin
            page_d = PG_START;
          end
        end
      end
      PG_ADMIN_ENTRY: begin
        if (!key_none && is_star) begin
          page_d = match_admin ? PG_ADMIN_AREA : PG_START;
        end
      end
      PG_VISIT_ENTRY: begin
        if (!key_none && is_star) begin
          page_d = PG_START;
        end
      end
      PG_ADMIN_AREA: begin
        if (!key_none) begin
          page_d = area_ok ? PG_NEW_CODE : PG_START;
        end
      end
      PG_VISIT_AREA: begin
        if (!key_none) begin
          page_d = area_ok ? PG_VISIT_ENTRY : PG_START;
        end
      end
      PG_NEW_CODE: begin
        if (!key_none && is_star) begin
          page_d = PG_START;
        end
      end
      default: begin
        page_d = PG_MODE;
      end
    endcase
  end

  // Status and store updates
  always_comb begin
    status   = ST_IDLE;
    gate     = 1'b0;
    clr_cnt  = 1'b0;
    take     = 1'b0;
    wr_entry = 1'b0;
    wr_area  = 1'b0;
    set_area = 1'b0;
    case (page_q)
      PG_MODE: begin
        if (!key_none) begin
          if (key_i == KeyModeAdmin) begin
            clr_cnt = 1'b1;
            status  = ST_ADMIN_PROMPT;
          end else if (key_i == KeyModeVisit) begin
            status  = ST_AREA_PROMPT;
          end else begin
            status  = ST_WRONG_CHOICE;
          end
        end
      end
      PG_ADMIN_ENTRY: begin
        if (!key_none) begin
          take     = 1'b1;
          wr_entry = 1'b1;
          status   = ST_KEY_TAKEN;
          if (is_star) begin
            status = match_admin ? ST_ADMIN_OK : ST_WRONG_CODE;
          end
        end
      end
      PG_VISIT_ENTRY: begin
        if (!key_none) begin
          take     = 1'b1;
          wr_entry = 1'b1;
          status   = ST_KEY_TAKEN;
          if (is_star) begin
            status = match_area ? ST_GATE_OPEN : ST_WRONG_CODE;
            gate   = match_area;
          end
        end
      end
      PG_ADMIN_AREA, PG_VISIT_AREA: begin
        if (!key_none) begin
          if (area_ok) begin
            set_area = 1'b1;
            clr_cnt  = 1'b1;
            status   = ST_CODE_PROMPT;
          end else begin
            status   = ST_WRONG_CHOICE;
          end
        end
      end
      PG_NEW_CODE: begin
        if (!key_none) begin
          take    = 1'b1;
          wr_area = 1'b1;
          status  = is_star ? ST_CODE_CHANGED : ST_KEY_TAKEN;
        end
      end
      default: begin
        status = ST_MODE_PROMPT;
      end
    endcase
  end

  // Key count saturates at the code length
  always_comb begin
    key_count_d = key_count_q;
    if (clr_cnt) begin
      key_count_d = '0;
    end else if (take && !full) begin
      key_count_d = key_count_q + CntW'(1);
    end
  end

  // Advance state on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q      <= PG_START;
      key_count_q <= '0;
      sel_q       <= '0;
      for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
        entry_q[i] <= NibEmpty;
      end
      for (int unsigned a = 0; a < NUM_AREAS; a++) begin
        for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
          area_q[a][i] <= NibNever;
        end
      end
    end else if (step_i) begin
      page_q      <= page_d;
      key_count_q <= key_count_d;
      if (set_area) begin
        sel_q <= AreaW'(key_i - KeyFirstArea);
      end
      if (wr_entry && !full) begin
        entry_q[wr_pos] <= key_i;
      end
      if (wr_area && !full) begin
        area_q[sel_q][wr_pos] <= key_i;
      end
    end
  end

  assign res_o.status         = status;
  assign res_o.gate_open      = gate;
  assign res_o.entry_position = 3'(key_count_d);

  // Gate opens only together with the gate-open status
  a_gate_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.gate_open |-> (res_o.status == ST_GATE_OPEN))
    else $error("gate open without matching status");

  // Key count never passes the code length
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= CntW'(CODE_LENGTH))
    else $error("key count beyond code length");

  // Any item on the start page leads to mode select
  a_start_to_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (page_q == PG_START)) |=> (page_q == PG_MODE))
    else $error("start page did not advance to mode select");

  // Choosing admin mode starts a fresh entry
  a_admin_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (page_q == PG_MODE) && (key_i == KeyModeAdmin))
      |=> ((key_count_q == '0) && (page_q == PG_ADMIN_ENTRY)))
    else $error("admin entry did not start cleared");

endmodule

`default_nettype wire

// ----- hdl/keypad_multi_code_lock.sv -----
// Keypad multi-area code lock: input register, menu logic and result register.
//
// Usage:
//   Input channel: one key_code_i per item (0-9 digits, 10 star, 11 hash,
//   12 to 15 no key), taken when in_valid_i is high and in_stall_o is low.
//   Output channel: one result per item (status_o, gate_open_o,
//   entry_position_o), taken when out_valid_o is high and out_stall_i low.
//   The admin code is written over the APB-style port at address 0 while no
//   item is in flight; pready is always high.
// Timing:
//   An accepted item is held in the input register, its result in the result
//   register. One item per cycle is sustained while out_stall_i is low; the menu
//   update for an item is a single pass of logic between these two registers.
// Reset:
//   Both channels empty, menu on the start page, entry buffer empty, area
//   codes set so they never match, admin code 0x1234.
// Stall:
//   A stalled result holds; one more item is held in the input register,
//   after which in_stall_o rises until the result is taken.
`default_nettype none

module keypad_multi_code_lock #(
  parameter int unsigned NUM_AREAS   = kmcl_pkg::NumAreasDef,
  parameter int unsigned CODE_LENGTH = kmcl_pkg::CodeLengthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [3:0]                    key_code_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    status_o,
  output logic                          gate_open_o,
  output logic [2:0]                    entry_position_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmcl_pkg::CfgAddrW-1:0] paddr,
  input  logic [kmcl_pkg::CfgDataW-1:0] pwdata,
  output logic [kmcl_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import kmcl_pkg::*;

  logic        s1_valid_q;
  logic [3:0]  s1_key_q;
  logic        out_valid_q;
  res_t        out_res_q;
  res_t        menu_res;
  logic        advance;
  logic        step;
  logic [15:0] admin_code;

  // Result register frees when empty or taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  kmcl_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .admin_code_o (admin_code)
  );

  kmcl_menu #(
    .NUM_AREAS   (NUM_AREAS),
    .CODE_LENGTH (CODE_LENGTH)
  ) u_menu (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .key_i        (s1_key_q),
    .admin_code_i (admin_code),
    .res_o        (menu_res)
  );

  // Input register: load whenever not holding a stalled item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_key_q <= key_code_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= menu_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign gate_open_o      = out_res_q.gate_open;
  assign entry_position_o = out_res_q.entry_position;

  // Input side stalls only with both registers full
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  // A stalled result keeps its value
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_res_q)))
    else $error("stalled result changed");

  // Each item in the input register moves on when the result side frees
  a_item_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("item lost between input and result register");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the keypad multi-area code lock: predictor, stimulus and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kmcl_pkg::*;

  localparam int unsigned NumAreas = NumAreasDef;
  localparam int unsigned CodeLen  = CodeLengthDef;
  localparam logic [3:0]  KeyHash  = 4'd11;
  localparam logic [CfgAddrW-1:0] AdminAddr = {RegAdminCode, 2'b00};
  localparam int unsigned PhaseItems = 300;

  localparam logic [3:0] DirectedKeys [25] = '{
    4'd13, KeyNone, KeyHash,                  // none on start, none in mode, hash in mode
    4'd0, KeyStar,                            // star is a wrong choice too
    4'd15, KeyModeAdmin,                      // enter admin code with a none key inside
    4'd1, 4'd2, 4'd14, 4'd3, 4'd4, KeyStar,   // fifth key (star) saturates the count
    4'd3,                                     // change the code of the third area
    4'd9, 4'd8, 4'd7, KeyStar,
    4'd5, KeyModeVisit, 4'd3,                 // visitor opens the third area
    4'd9, 4'd8, 4'd7, KeyStar
  };

  // Predicts the lock menu item by item and holds the results still to come
  class lock_scoreboard;
    logic [15:0]  admin_code = AdminCodeRst;
    page_e        page       = PG_START;
    logic [3:0]   entry_nib [CodeLen];
    logic [3:0]   area_nib [NumAreas][CodeLen];
    int unsigned  key_count  = 0;
    int unsigned  sel_area   = 0;
    res_t         result_q [$];
    int unsigned  errors     = 0;

    function void clear_stores();
      foreach (entry_nib[i]) entry_nib[i] = NibEmpty;
      foreach (area_nib[a, i]) area_nib[a][i] = NibNever;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    // Advance the menu by one accepted key and queue the result it causes
    function void note_key(logic [3:0] k);
      status_e    st;
      logic       gate;
      logic       hit;
      logic [3:0] want;
      st   = ST_IDLE;
      gate = 1'b0;
      if (!(page != PG_START && k >= KeyNone)) begin
        case (page)
          PG_START: begin
            page = PG_MODE;
            st   = ST_MODE_PROMPT;
          end
          PG_MODE: begin
            if (k == KeyModeAdmin) begin
              page      = PG_ADMIN_ENTRY;
              key_count = 0;
              st        = ST_ADMIN_PROMPT;
            end else if (k == KeyModeVisit) begin
              page = PG_VISIT_AREA;
              st   = ST_AREA_PROMPT;
            end else begin
              page = PG_START;
              st   = ST_WRONG_CHOICE;
            end
          end
          PG_ADMIN_ENTRY, PG_VISIT_ENTRY: begin
            if (key_count < CodeLen) begin
              entry_nib[key_count] = k;
              key_count++;
            end
            st = ST_KEY_TAKEN;
            if (k == KeyStar) begin
              hit = 1'b1;
              for (int i = 0; i < CodeLen; i++) begin
                if (page == PG_ADMIN_ENTRY)
                  want = 4'(32'(admin_code) >> (4 * (CodeLen - 1 - i)));
                else
                  want = area_nib[sel_area][i];
                if (entry_nib[i] != want) hit = 1'b0;
              end
              if (page == PG_ADMIN_ENTRY) begin
                page = hit ? PG_ADMIN_AREA : PG_START;
                st   = hit ? ST_ADMIN_OK : ST_WRONG_CODE;
              end else begin
                page = PG_START;
                st   = hit ? ST_GATE_OPEN : ST_WRONG_CODE;
                gate = hit;
              end
            end
          end
          PG_ADMIN_AREA, PG_VISIT_AREA: begin
            if (k >= KeyFirstArea && k < KeyFirstArea + NumAreas) begin
              sel_area  = k - KeyFirstArea;
              key_count = 0;
              page      = (page == PG_ADMIN_AREA) ? PG_NEW_CODE : PG_VISIT_ENTRY;
              st        = ST_CODE_PROMPT;
            end else begin
              page = PG_START;
              st   = ST_WRONG_CHOICE;
            end
          end
          default: begin
            // new code keys go straight into the selected area
            if (key_count < CodeLen) begin
              area_nib[sel_area][key_count] = k;
              key_count++;
            end
            st = ST_KEY_TAKEN;
            if (k == KeyStar) begin
              page = PG_START;
              st   = ST_CODE_CHANGED;
            end
          end
        endcase
      end
      result_q.push_back(res_t'{st, gate, 3'(key_count)});
    endfunction

    // Compare one result from the block with the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (result_q.size() == 0) begin
        report($sformatf("result with no item pending: status %0d gate %0b pos %0d",
                         got.status, got.gate_open, got.entry_position));
        return;
      end
      want = result_q.pop_front();
      if (got.status != want.status)
        report($sformatf("status expected %0d got %0d", want.status, got.status));
      if (got.gate_open != want.gate_open)
        report($sformatf("gate_open expected %0b got %0b", want.gate_open, got.gate_open));
      if (got.entry_position != want.entry_position)
        report($sformatf("entry_position expected %0d got %0d",
                         want.entry_position, got.entry_position));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [3:0]          key_code_i  = 4'd0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [3:0]          status_o;
  logic                gate_open_o;
  logic [2:0]          entry_position_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  lock_scoreboard sb = new;
  bit             calm = 1'b0;
  int unsigned    keys_taken = 0;
  int unsigned    stall_left = 0;

  keypad_multi_code_lock uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .key_code_i,
    .out_valid_o, .out_stall_i, .status_o, .gate_open_o, .entry_position_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // Stall the result side in random bursts
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  = $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every result the block hands over
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(res_t'{status_e'(status_o), gate_open_o, entry_position_o});
  end

  // Drive one item and hold it until the block takes it
  task automatic send_key(input logic [3:0] k);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    key_code_i <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    keys_taken++;
    sb.note_key(k);
  endtask

  task automatic pause(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Send a key with random gaps and stray no-key scans in front of it
  task automatic press(input logic [3:0] k);
    if (!calm && $urandom_range(0, 5) == 0) pause($urandom_range(1, 5));
    if (sb.page != PG_START && $urandom_range(0, 9) == 0)
      send_key(4'(KeyNone + $urandom_range(0, 3)));
    send_key(k);
  endtask

  function automatic logic [3:0] any_key();
    return 4'($urandom_range(0, 15));
  endfunction

  // Digit mostly, hash now and then; never star
  function automatic logic [3:0] code_key();
    return ($urandom_range(0, 11) == 0) ? KeyHash : 4'($urandom_range(0, 9));
  endfunction

  function automatic logic [15:0] digit_code();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // Leave whatever page the menu is on
  task automatic go_home();
    while (sb.page != PG_START)
      press((sb.page inside {PG_ADMIN_ENTRY, PG_VISIT_ENTRY, PG_NEW_CODE}) ? KeyStar : KeyHash);
  endtask

  task automatic pick_area();
    press(($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 11))
                                      : 4'($urandom_range(KeyFirstArea, NumAreas)));
  endtask

  task automatic random_entry();
    repeat ($urandom_range(0, 6)) press(code_key());
  endtask

  // Admin login followed by a code change, mostly well formed
  task automatic admin_session();
    int unsigned len;
    press(any_key());
    press(($urandom_range(0, 9) == 0) ? any_key() : KeyModeAdmin);
    if (sb.page != PG_ADMIN_ENTRY) return;
    if ($urandom_range(0, 4) != 0) begin
      for (int i = 0; i < CodeLen; i++)
        if (sb.page == PG_ADMIN_ENTRY)
          press(4'(32'(sb.admin_code) >> (4 * (CodeLen - 1 - i))));
    end else begin
      random_entry();
    end
    if (sb.page == PG_ADMIN_ENTRY) press(KeyStar);
    if (sb.page != PG_ADMIN_AREA) return;
    pick_area();
    if (sb.page != PG_NEW_CODE) return;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : CodeLen;
    repeat (len) press(code_key());
    press(KeyStar);
  endtask

  // Visitor area pick and code entry, mostly with the stored code
  task automatic visit_session();
    press(any_key());
    press(($urandom_range(0, 9) == 0) ? any_key() : KeyModeVisit);
    if (sb.page != PG_VISIT_AREA) return;
    pick_area();
    if (sb.page != PG_VISIT_ENTRY) return;
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < CodeLen; i++)
        if (sb.page == PG_VISIT_ENTRY) press(sb.area_nib[sb.sel_area][i]);
    end else begin
      random_entry();
    end
    if (sb.page == PG_VISIT_ENTRY) press(KeyStar);
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned target;
    target = keys_taken + n;
    while (keys_taken < target) begin
      go_home();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: admin_session();
        4, 5, 6, 7: visit_session();
        default:    repeat ($urandom_range(1, 6)) press(any_key());
      endcase
    end
  endtask

  // Wait until the block has drained every item
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_access(input logic wr, input logic [CfgDataW-1:0] data,
                            output logic [CfgDataW-1:0] rd);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AdminAddr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_readback();
    logic [CfgDataW-1:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd != CfgDataW'(sb.admin_code))
      sb.report($sformatf("admin_code readback expected %h got %h", sb.admin_code, rd));
  endtask

  task automatic set_admin_code(input logic [15:0] code);
    logic [CfgDataW-1:0] rd;
    settle();
    cfg_access(1'b1, CfgDataW'(code), rd);
    sb.admin_code = code;
    cfg_readback();
  endtask

  // Main sequence: reset, directed keys, then random phases over several admin codes
  initial begin
    logic [15:0] codes [5];
    sb.clear_stores();
    codes = '{16'h0000, 16'hFFFF, 16'h999A, 16'(digit_code() ^ $urandom), digit_code()};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    cfg_readback();
    foreach (DirectedKeys[i]) send_key(DirectedKeys[i]);
    run_phase(PhaseItems);
    foreach (codes[i]) begin
      set_admin_code(codes[i]);
      if (i == 4) calm = 1'b1;
      run_phase(PhaseItems);
    end
    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
